### rtl/core/mtq_pkg.sv
// Shared types and constants of the millisecond timer expiry queue.
// Used by mtq_ctrl, mtq_dp and multi_timer_expiry_queue; depends on nothing.
package mtq_pkg;

	localparam int NUM_TIMERS = 32;
	localparam int ID_W       = 5;
	localparam int CNT_W      = 6;
	localparam int TIME_W     = 48;
	localparam int PER_W      = 31;
	localparam int EL_W       = 16;
	localparam int NRES_W     = 7;
	localparam int MAX_RES    = 2 * NUM_TIMERS;
	localparam logic [PER_W-1:0]  OVR_MAX  = {PER_W{1'b1}};
	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

	localparam logic [2:0] KIND_TICK  = 3'd0;
	localparam logic [2:0] KIND_ADD   = 3'd1;
	localparam logic [2:0] KIND_DEL   = 3'd2;
	localparam logic [2:0] KIND_START = 3'd3;
	localparam logic [2:0] KIND_STOP  = 3'd4;
	localparam logic [2:0] KIND_SETP  = 3'd5;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_NOFREE  = 2'd2;
	localparam logic [1:0] ST_BADPER  = 2'd3;

	typedef struct packed {
		logic [2:0]       kind;
		logic [ID_W-1:0]  timer_id;
		logic [PER_W-1:0] period_ms;
		logic             oneshot;
		logic             start_stopped;
		logic [EL_W-1:0]  elapsed_ms;
	} in_item_t;

	typedef struct packed {
		logic [ID_W-1:0]  result_timer;
		logic [1:0]       status;
		logic             is_expiry;
		logic [PER_W-1:0] overrun;
		logic             last;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic ld;
		logic exec;
		logic tadv;
		logic ptr_clr;
		logic ptr_inc;
		logic rm_shift;
		logic ins_shift;
		logic pop;
		logic rel;
		logic div_step;
		logic fin;
		logic look;
		logic emit;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_tick;
		logic bad_kind;
		logic do_rm;
		logic do_ins;
		logic rm_hit;
		logic ins_here;
		logic due;
		logic n_ok;
		logic relz;
		logic late;
		logic div_done;
		logic out_free;
		logic last;
	} dp_stat_t;

endpackage

### rtl/core/mtq_ctrl.sv
// Controller state machine of the timer expiry queue.
// Depends on mtq_pkg for the command and status structs.
module mtq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  mtq_pkg::dp_stat_t  st,
	output mtq_pkg::dp_cmd_t   cmd
);

	typedef enum logic [12:0] {
		S_IDLE     = 13'b0000000000001,
		S_DEC      = 13'b0000000000010,
		S_RM_SCAN  = 13'b0000000000100,
		S_RM_SHIFT = 13'b0000000001000,
		S_INS_SCAN = 13'b0000000010000,
		S_INS_SHFT = 13'b0000000100000,
		S_HEAD     = 13'b0000001000000,
		S_REL      = 13'b0000010000000,
		S_DIV      = 13'b0000100000000,
		S_FIN      = 13'b0001000000000,
		S_LOOK     = 13'b0010000000000,
		S_EMIT     = 13'b0100000000000,
		S_ROUTE    = 13'b1000000000000
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	// sequence the datapath
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.ld  = 1'b1;
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				cmd.ptr_clr = 1'b1;
				if (st.is_tick) begin
					cmd.tadv = 1'b1;
					state_d  = S_HEAD;
				end else if (st.bad_kind) begin
					state_d = S_IDLE;
				end else begin
					cmd.exec = 1'b1;
					state_d  = S_ROUTE;
				end
			end
			// a command that touches the queue removes before it replies
			S_ROUTE: begin
				if (st.do_rm) begin
					state_d = S_RM_SCAN;
				end else if (st.do_ins) begin
					state_d = S_INS_SCAN;
				end else begin
					state_d = S_EMIT;
				end
			end
			S_RM_SCAN: begin
				if (st.rm_hit) begin
					state_d = S_RM_SHIFT;
				end else begin
					cmd.ptr_inc = 1'b1;
				end
			end
			S_RM_SHIFT: begin
				cmd.rm_shift = 1'b1;
				cmd.ptr_clr  = 1'b1;
				if (st.is_tick) begin
					state_d = S_REL;
				end else if (st.do_ins) begin
					state_d = S_INS_SCAN;
				end else begin
					state_d = S_EMIT;
				end
			end
			S_INS_SCAN: begin
				if (st.ins_here) begin
					state_d = S_INS_SHFT;
				end else begin
					cmd.ptr_inc = 1'b1;
				end
			end
			S_INS_SHFT: begin
				cmd.ins_shift = 1'b1;
				cmd.ptr_clr   = 1'b1;
				state_d       = st.is_tick ? S_LOOK : S_EMIT;
			end
			S_HEAD: begin
				if (st.due && st.n_ok) begin
					cmd.pop = 1'b1;
					state_d = S_RM_SHIFT;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_REL: begin
				cmd.rel     = 1'b1;
				cmd.ptr_clr = 1'b1;
				if (st.relz) begin
					state_d = S_LOOK;
				end else if (st.late) begin
					state_d = S_DIV;
				end else begin
					state_d = S_INS_SCAN;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (st.div_done) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				cmd.fin     = 1'b1;
				cmd.ptr_clr = 1'b1;
				state_d     = S_INS_SCAN;
			end
			S_LOOK: begin
				cmd.look = 1'b1;
				state_d  = S_EMIT;
			end
			S_EMIT: begin
				cmd.ptr_clr = 1'b1;
				if (st.out_free) begin
					cmd.emit = 1'b1;
					if (st.is_tick && !st.last) begin
						state_d = S_HEAD;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef SYNTH
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ld |=> (state_q == S_DEC))
		else $error("item load did not lead to decode");
	a_emit_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && !st.out_free) |=> (state_q == S_EMIT))
		else $error("result dropped while output busy");
	a_div_only: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |-> $past(cmd.div_step))
		else $error("finish without divider run");
`endif

endmodule

### rtl/core/mtq_dp.sv
// Datapath of the timer expiry queue: timer stores, ordered queue, free ring,
// overrun divider and output register. Depends on mtq_pkg.
module mtq_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  mtq_pkg::in_item_t   in_item,
	input  mtq_pkg::dp_cmd_t    cmd,
	output mtq_pkg::dp_stat_t   st,
	output logic                out_valid,
	input  logic                out_ready,
	output mtq_pkg::out_item_t  out_item
);

	localparam int TW = mtq_pkg::TIME_W;
	localparam int PW = mtq_pkg::PER_W;
	localparam int IW = mtq_pkg::ID_W;
	localparam int NT = mtq_pkg::NUM_TIMERS;
	localparam int CW = mtq_pkg::CNT_W;

	mtq_pkg::in_item_t item_q;
	logic [TW-1:0] now_q;
	logic [NT-1:0] in_use_q, armed_q, oneshot_q;
	logic [PW-1:0] period_q [NT];
	logic [PW-1:0] reload_q [NT];
	logic [TW-1:0] exp_q    [NT];
	logic [IW-1:0] qord_q   [NT];
	logic [CW-1:0] qlen_q;
	logic [IW-1:0] ring_q   [NT];
	logic [IW-1:0] fhead_q;
	logic [CW-1:0] fcnt_q;
	logic [IW-1:0] ptr_q, tid_q, rtimer_q;
	logic [TW-1:0] exp_tid_q;
	logic [1:0]    status_q;
	logic [PW-1:0] ov_q;
	logic          last_q, do_rm_q, do_ins_q;
	logic [mtq_pkg::NRES_W-1:0] nres_q;
	logic [TW-1:0] dq_q;
	logic [PW-1:0] rem_q;
	logic [CW-1:0] dcnt_q;
	logic          ov_valid_q;
	mtq_pkg::out_item_t out_q;

	logic [TW-1:0] exp_rd, e1, now_adv, arm_exp, fin_exp;
	logic [PW-1:0] iv;
	logic [TW:0]   s_e1, s_now, s_arm, s_fin;
	logic [PW:0]   dtmp;
	logic          dge;
	logic [TW:0]   skips;
	logic [PW-1:0] rpart;
	logic          valid_id;
	logic [IW-1:0] id, ring_wr;

	assign id       = item_q.timer_id;
	assign valid_id = in_use_q[id];
	assign exp_rd   = exp_q[qord_q[ptr_q]];
	assign iv       = reload_q[tid_q];

	// saturating time sums
	assign s_now   = {1'b0, now_q} + {{(TW+1-mtq_pkg::EL_W){1'b0}}, item_q.elapsed_ms};
	assign now_adv = s_now[TW] ? mtq_pkg::TIME_MAX : s_now[TW-1:0];
	assign s_e1    = {1'b0, exp_tid_q} + {{(TW+1-PW){1'b0}}, iv};
	assign e1      = s_e1[TW] ? mtq_pkg::TIME_MAX : s_e1[TW-1:0];
	assign s_arm   = {1'b0, now_q} + {{(TW+1-PW){1'b0}}, item_q.period_ms};
	assign arm_exp = s_arm[TW] ? mtq_pkg::TIME_MAX : s_arm[TW-1:0];

	// one restoring divide step
	assign dtmp = {rem_q, dq_q[TW-1]};
	assign dge  = dtmp >= {1'b0, iv};

	// overrun and phase from quotient and remainder
	assign skips   = {1'b0, dq_q} + {{TW{1'b0}}, (rem_q != '0)};
	assign rpart   = (rem_q == '0) ? '0 : iv - rem_q;
	assign s_fin   = {1'b0, now_q} + {{(TW+1-PW){1'b0}}, rpart};
	assign fin_exp = s_fin[TW] ? mtq_pkg::TIME_MAX : s_fin[TW-1:0];

	assign ring_wr = fhead_q + fcnt_q[IW-1:0];

	// status to controller
	always_comb begin
		st          = '0;
		st.is_tick  = (item_q.kind == mtq_pkg::KIND_TICK);
		st.bad_kind = (item_q.kind > mtq_pkg::KIND_SETP);
		st.do_rm    = do_rm_q;
		st.do_ins   = do_ins_q;
		st.rm_hit   = (qord_q[ptr_q] == tid_q);
		st.ins_here = ({1'b0, ptr_q} == qlen_q) || (exp_rd > exp_tid_q);
		st.due      = (qlen_q != '0) && (exp_rd <= now_q);
		st.n_ok     = (nres_q < mtq_pkg::NRES_W'(mtq_pkg::MAX_RES));
		st.relz     = (iv == '0);
		st.late     = (e1 < now_q);
		st.div_done = (dcnt_q == CW'(TW - 1));
		st.out_free = !out_valid || out_ready;
		st.last     = last_q;
	end

	// control state of the pool and the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q    <= '0;
			in_use_q <= '0;
			armed_q  <= '0;
			qlen_q   <= '0;
			fhead_q  <= '0;
			fcnt_q   <= CW'(NT);
			for (int i = 0; i < NT; i++) begin
				ring_q[i] <= IW'(i);
			end
			ov_valid_q <= 1'b0;
		end else begin
			if (cmd.tadv) begin
				now_q <= now_adv;
			end
			if (cmd.exec) begin
				unique case (item_q.kind)
					mtq_pkg::KIND_ADD: begin
						if (item_q.period_ms != '0 && fcnt_q != '0) begin
							fhead_q                   <= fhead_q + 1'b1;
							fcnt_q                    <= fcnt_q - 1'b1;
							in_use_q[ring_q[fhead_q]] <= 1'b1;
							armed_q[ring_q[fhead_q]]  <= !item_q.start_stopped;
						end
					end
					mtq_pkg::KIND_DEL: begin
						if (valid_id) begin
							armed_q[id]     <= 1'b0;
							in_use_q[id]    <= 1'b0;
							ring_q[ring_wr] <= id;
							fcnt_q          <= fcnt_q + 1'b1;
						end
					end
					mtq_pkg::KIND_START: begin
						if (valid_id) begin
							armed_q[id] <= 1'b1;
						end
					end
					mtq_pkg::KIND_STOP: begin
						if (valid_id) begin
							armed_q[id] <= 1'b0;
						end
					end
					default: ;
				endcase
			end
			if (cmd.rm_shift) begin
				qlen_q <= qlen_q - 1'b1;
			end
			if (cmd.ins_shift) begin
				qlen_q <= qlen_q + 1'b1;
			end
			if (cmd.rel && iv == '0) begin
				armed_q[tid_q] <= 1'b0;
			end
			if (cmd.emit) begin
				ov_valid_q <= 1'b1;
			end else if (out_ready) begin
				ov_valid_q <= 1'b0;
			end
		end
	end

	// payload registers and timer stores
	always_ff @(posedge clk) begin
		if (cmd.ld) begin
			item_q <= in_item;
			nres_q <= '0;
		end
		if (cmd.ptr_clr) begin
			ptr_q <= '0;
		end else if (cmd.ptr_inc) begin
			ptr_q <= ptr_q + 1'b1;
		end
		if (cmd.exec) begin
			do_rm_q  <= 1'b0;
			do_ins_q <= 1'b0;
			ov_q     <= '0;
			last_q   <= 1'b1;
			rtimer_q <= id;
			tid_q    <= id;
			status_q <= mtq_pkg::ST_OK;
			unique case (item_q.kind)
				mtq_pkg::KIND_ADD: begin
					rtimer_q <= '0;
					if (item_q.period_ms == '0) begin
						status_q <= mtq_pkg::ST_BADPER;
					end else if (fcnt_q == '0) begin
						status_q <= mtq_pkg::ST_NOFREE;
					end else begin
						rtimer_q                   <= ring_q[fhead_q];
						tid_q                      <= ring_q[fhead_q];
						oneshot_q[ring_q[fhead_q]] <= item_q.oneshot;
						period_q[ring_q[fhead_q]]  <= item_q.period_ms;
						reload_q[ring_q[fhead_q]]  <= '0;
						if (!item_q.start_stopped) begin
							exp_q[ring_q[fhead_q]]  <= arm_exp;
							exp_tid_q               <= arm_exp;
							reload_q[ring_q[fhead_q]] <= item_q.oneshot ? '0 : item_q.period_ms;
							do_ins_q                <= 1'b1;
						end
					end
				end
				mtq_pkg::KIND_DEL, mtq_pkg::KIND_STOP: begin
					if (!valid_id) begin
						status_q <= mtq_pkg::ST_INVALID;
					end else begin
						do_rm_q <= armed_q[id];
						if (item_q.kind == mtq_pkg::KIND_STOP) begin
							reload_q[id] <= '0;
						end
					end
				end
				mtq_pkg::KIND_START: begin
					if (!valid_id) begin
						status_q <= mtq_pkg::ST_INVALID;
					end else begin
						// restart from now with the stored period
						do_rm_q      <= armed_q[id];
						do_ins_q     <= 1'b1;
						exp_q[id]    <= {{(TW-PW){1'b0}}, period_q[id]} + now_q > now_q ?
							((({1'b0, now_q} + {{(TW+1-PW){1'b0}}, period_q[id]}) >>
							TW) != '0 ? mtq_pkg::TIME_MAX :
							now_q + {{(TW-PW){1'b0}}, period_q[id]}) : mtq_pkg::TIME_MAX;
						exp_tid_q    <= (({1'b0, now_q} + {{(TW+1-PW){1'b0}}, period_q[id]})
							>> TW) != '0 ? mtq_pkg::TIME_MAX :
							now_q + {{(TW-PW){1'b0}}, period_q[id]};
						reload_q[id] <= oneshot_q[id] ? '0 : period_q[id];
					end
				end
				mtq_pkg::KIND_SETP: begin
					if (item_q.period_ms == '0) begin
						status_q <= mtq_pkg::ST_BADPER;
					end else if (!valid_id) begin
						status_q <= mtq_pkg::ST_INVALID;
					end else begin
						period_q[id] <= item_q.period_ms;
					end
				end
				default: ;
			endcase
		end
		// shift queue entries
		if (cmd.rm_shift) begin
			for (int j = 0; j < NT - 1; j++) begin
				if (IW'(j) >= ptr_q) begin
					qord_q[j] <= qord_q[j+1];
				end
			end
		end
		if (cmd.ins_shift) begin
			for (int j = 1; j < NT; j++) begin
				if (IW'(j) > ptr_q) begin
					qord_q[j] <= qord_q[j-1];
				end
			end
			qord_q[ptr_q] <= tid_q;
		end
		if (cmd.pop) begin
			tid_q     <= qord_q[ptr_q];
			exp_tid_q <= exp_rd;
		end
		// reload a fired timer
		if (cmd.rel) begin
			ov_q <= '0;
			if (iv != '0 && !(e1 < now_q)) begin
				exp_q[tid_q] <= e1;
				exp_tid_q    <= e1;
			end
			dq_q   <= now_q - e1;
			rem_q  <= '0;
			dcnt_q <= '0;
		end
		if (cmd.div_step) begin
			dq_q   <= {dq_q[TW-2:0], dge};
			rem_q  <= dge ? PW'(dtmp - {1'b0, iv}) : dtmp[PW-1:0];
			dcnt_q <= dcnt_q + 1'b1;
		end
		if (cmd.fin) begin
			ov_q         <= (skips > {{(TW+1-PW){1'b0}}, mtq_pkg::OVR_MAX}) ?
				mtq_pkg::OVR_MAX : skips[PW-1:0];
			exp_q[tid_q] <= fin_exp;
			exp_tid_q    <= fin_exp;
		end
		if (cmd.look) begin
			last_q <= !(st.due && (nres_q < mtq_pkg::NRES_W'(mtq_pkg::MAX_RES - 1)));
		end
		// load the output register
		if (cmd.emit) begin
			nres_q                <= nres_q + 1'b1;
			out_q.result_timer    <= st.is_tick ? tid_q : rtimer_q;
			out_q.status          <= st.is_tick ? mtq_pkg::ST_OK : status_q;
			out_q.is_expiry       <= st.is_tick;
			out_q.overrun         <= st.is_tick ? ov_q : '0;
			out_q.last            <= last_q;
		end
	end

	assign out_valid = ov_valid_q;
	assign out_item  = out_q;

`ifndef SYNTH
	a_pool_count: assert property (@(posedge clk) disable iff (!arst_n)
		($countones(in_use_q) + fcnt_q) == NT)
		else $error("free count disagrees with allocated timers");
	a_armed_used: assert property (@(posedge clk) disable iff (!arst_n)
		(armed_q & ~in_use_q) == '0)
		else $error("armed timer not allocated");
	a_qlen_range: assert property (@(posedge clk) disable iff (!arst_n)
		qlen_q <= CW'(NT))
		else $error("queue length out of range");
`endif

endmodule

### rtl/core/multi_timer_expiry_queue.sv
// Millisecond timer pool with an expiry queue ordered by time.
// One request at a time: a command runs from accept to the next accept through the
// serial queue scans (one entry per cycle); an unknown kind returns straight to idle.
// A tick ends when nothing is due, else pops the due timers in turn, running the
// 48-step overrun divider for a late one; a stalled output holds the queue until taken.
// Reset: time zero, no timers allocated, free ring 0..31 ascending.
module multi_timer_expiry_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  mtq_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output mtq_pkg::out_item_t out_item
);

	mtq_pkg::dp_cmd_t  cmd;
	mtq_pkg::dp_stat_t st;

	// sequencer
	mtq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	// stores, queue and output register
	mtq_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.cmd       (cmd),
		.st        (st),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule
